/* rtl/pvwrgb_pkg.sv */
// Shared widths, field layout and pixel type for the packed video word converter.
package pvwrgb_pkg;

    localparam int WORD_W   = 64;
    localparam int COMP_W   = 10;
    localparam int PIX_W    = 8;
    localparam int NUM_COMP = 6;

    // Component slots within the packed word.
    localparam int SLOT_Y0 = 0;
    localparam int SLOT_U  = 1;
    localparam int SLOT_Y1 = 2;
    localparam int SLOT_V  = 3;

    // Source format select.
    localparam logic MODE_YUV422 = 1'b0;
    localparam logic MODE_RGB    = 1'b1;

    typedef logic [PIX_W-1:0] comp_t;

    typedef struct packed {
        comp_t red;
        comp_t green;
        comp_t blue;
    } rgb_t;

    // One lane's source components.
    typedef struct packed {
        logic  src_mode;
        rgb_t  direct;
        comp_t luma;
        comp_t cb;
        comp_t cr;
    } lane_in_t;

endpackage

/* rtl/pvwrgb_scale.sv */
// 10-bit to 8-bit component scaler: floor(x*255/1023) without a divider.
module pvwrgb_scale (
    input  logic [pvwrgb_pkg::COMP_W-1:0] comp_in,
    output pvwrgb_pkg::comp_t             comp_out
);
    import pvwrgb_pkg::*;

    logic [17:0] prod;
    logic [7:0]  quot_lo;
    logic [17:0] rem;

    // x*255 = (x << 8) - x; n/1024 is at most one below n/1023.
    assign prod    = {comp_in, 8'b0} - 18'(comp_in);
    assign quot_lo = prod[17:10];
    assign rem     = prod - {quot_lo, 10'b0} + 18'(quot_lo);
    assign comp_out = quot_lo + 8'(rem >= 18'd1023);

endmodule

/* rtl/pvwrgb_lane.sv */
// One pixel lane: BT.601 integer YCbCr to RGB with clamp, or direct RGB.
module pvwrgb_lane (
    input  pvwrgb_pkg::lane_in_t lane_in,
    output pvwrgb_pkg::rgb_t     pix_out
);
    import pvwrgb_pkg::*;

    logic signed [9:0]  c_term;
    logic signed [8:0]  d_term;
    logic signed [8:0]  e_term;
    logic signed [19:0] luma_p;
    logic signed [19:0] sum_r;
    logic signed [19:0] sum_g;
    logic signed [19:0] sum_b;

    function automatic comp_t clamp8(input logic signed [19:0] sum);
        logic signed [11:0] q;
        q = sum[19:8];  // arithmetic >> 8
        if (q < 12'sd0)
            clamp8 = '0;
        else if (q > 12'sd255)
            clamp8 = 8'd255;
        else
            clamp8 = q[7:0];
    endfunction

    assign c_term = $signed({2'b00, lane_in.luma}) - 10'sd16;
    assign d_term = $signed({1'b0, lane_in.cb}) - 9'sd128;
    assign e_term = $signed({1'b0, lane_in.cr}) - 9'sd128;

    assign luma_p = 20'(c_term) * 20'sd298 + 20'sd128;
    assign sum_r  = luma_p + 20'(e_term) * 20'sd409;
    assign sum_g  = luma_p - 20'(d_term) * 20'sd100 - 20'(e_term) * 20'sd208;
    assign sum_b  = luma_p + 20'(d_term) * 20'sd516;

    always_comb begin
        if (lane_in.src_mode == MODE_RGB) begin
            pix_out = lane_in.direct;
        end else begin
            pix_out.red   = clamp8(sum_r);
            pix_out.green = clamp8(sum_g);
            pix_out.blue  = clamp8(sum_b);
        end
    end

endmodule

/* rtl/packed_video_word_to_rgb888.sv */
// Top level: packed two-pixel video word to two RGB888 pixels.
// Input channel s_valid/s_ready carries one 64-bit packed word per item;
// result channel m_valid/m_ready carries two RGB888 pixels per word.
// The cfg_valid/cfg_ready channel writes the one mode bit (1 = packed
// 10-bit RGB, 0 = packed 10-bit YUV422); cfg_ready is always high and the
// bit is to be written only while no word is in flight.
// Six scaler lanes bring every 10-bit component to 8 bits into a stage
// register; two pixel lanes then convert in parallel, sharing Cb and Cr,
// and the merge stage packs both pixels into the output register.
// An accepted word goes to the stage register, then to the output register.
// Throughput is one word per cycle while m_ready is high: both stages move.
// When the receiver stalls, the output register holds its word and the
// scaler stage still takes one more word; s_ready drops once both are full.
// Synchronous active-low reset empties both stages and clears the mode to
// YUV422; no word is lost or duplicated across stalls.
module packed_video_word_to_rgb888 (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_rgb_passthrough_mode,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pvwrgb_pkg::WORD_W-1:0] s_packed_word,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pvwrgb_pkg::comp_t             m_red_first,
    output pvwrgb_pkg::comp_t             m_green_first,
    output pvwrgb_pkg::comp_t             m_blue_first,
    output pvwrgb_pkg::comp_t             m_red_second,
    output pvwrgb_pkg::comp_t             m_green_second,
    output pvwrgb_pkg::comp_t             m_blue_second
);
    import pvwrgb_pkg::*;

    logic     mode_reg;
    logic     s1_valid_reg;
    logic     out_valid_reg;
    comp_t    scaled_next [NUM_COMP];
    comp_t    scaled_reg  [NUM_COMP];
    rgb_t     pix0_out;
    rgb_t     pix1_out;
    rgb_t     pix0_reg;
    rgb_t     pix1_reg;
    lane_in_t lane0_in;
    lane_in_t lane1_in;
    logic     load_out;
    logic     load_s1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            mode_reg <= MODE_YUV422;
        else if (cfg_valid)
            mode_reg <= cfg_rgb_passthrough_mode;
    end

    // Scaler lanes, one per 10-bit slot.
    for (genvar k = 0; k < NUM_COMP; k++) begin : g_scale
        pvwrgb_scale u_scale (
            .comp_in  (s_packed_word[k*COMP_W +: COMP_W]),
            .comp_out (scaled_next[k])
        );
    end

    assign load_out = s1_valid_reg && (!out_valid_reg || m_ready);
    assign load_s1  = !s1_valid_reg || load_out;
    assign s_ready  = load_s1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_s1)
                s1_valid_reg <= s_valid;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_s1 && s_valid)
            scaled_reg <= scaled_next;
        if (load_out) begin
            pix0_reg <= pix0_out;
            pix1_reg <= pix1_out;
        end
    end

    // Both pixel lanes share Cb/Cr; direct RGB uses slots 0..2 and 3..5.
    assign lane0_in = '{src_mode: mode_reg,
                        direct:   '{red: scaled_reg[0], green: scaled_reg[1],
                                    blue: scaled_reg[2]},
                        luma:     scaled_reg[SLOT_Y0],
                        cb:       scaled_reg[SLOT_U],
                        cr:       scaled_reg[SLOT_V]};
    assign lane1_in = '{src_mode: mode_reg,
                        direct:   '{red: scaled_reg[3], green: scaled_reg[4],
                                    blue: scaled_reg[5]},
                        luma:     scaled_reg[SLOT_Y1],
                        cb:       scaled_reg[SLOT_U],
                        cr:       scaled_reg[SLOT_V]};

    pvwrgb_lane u_lane0 (
        .lane_in (lane0_in),
        .pix_out (pix0_out)
    );

    pvwrgb_lane u_lane1 (
        .lane_in (lane1_in),
        .pix_out (pix1_out)
    );

    assign m_valid        = out_valid_reg;
    assign m_red_first    = pix0_reg.red;
    assign m_green_first  = pix0_reg.green;
    assign m_blue_first   = pix0_reg.blue;
    assign m_red_second   = pix1_reg.red;
    assign m_green_second = pix1_reg.green;
    assign m_blue_second  = pix1_reg.blue;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the packed two-pixel video word to RGB888 converter.
module tb_top;
    import pvwrgb_pkg::*;

    localparam int   LATENCY     = 2;
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct packed {
        rgb_t first;
        rgb_t second;
    } pixel_pair_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_rgb_passthrough_mode = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [WORD_W-1:0] s_packed_word = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    comp_t             m_red_first, m_green_first, m_blue_first;
    comp_t             m_red_second, m_green_second, m_blue_second;

    pixel_pair_t pending_pairs[$];
    logic        mode_shadow = MODE_YUV422;
    int          error_count = 0;
    int          burst_left = 0;
    int          hold_left = 0;
    int          cycle_count = 0;

    packed_video_word_to_rgb888 u_top (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .cfg_valid                (cfg_valid),
        .cfg_ready                (cfg_ready),
        .cfg_rgb_passthrough_mode (cfg_rgb_passthrough_mode),
        .s_valid                  (s_valid),
        .s_ready                  (s_ready),
        .s_packed_word            (s_packed_word),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_red_first              (m_red_first),
        .m_green_first            (m_green_first),
        .m_blue_first             (m_blue_first),
        .m_red_second             (m_red_second),
        .m_green_second           (m_green_second),
        .m_blue_second            (m_blue_second)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------- prediction ----------------

    function automatic comp_t scale_comp(input logic [WORD_W-1:0] w, input int slot);
        int x;
        x = int'(w[slot*COMP_W +: COMP_W]);
        return comp_t'((x * 255) / 1023);
    endfunction

    function automatic comp_t shift_clamp(input int sum);
        int q;
        q = sum >>> 8;
        if (q < 0) return '0;
        if (q > 255) return 8'hFF;
        return comp_t'(q);
    endfunction

    function automatic rgb_t yuv_pixel(input comp_t luma, input int d, input int e);
        rgb_t px;
        int   c;
        c = int'(luma) - 16;
        px.red   = shift_clamp(298 * c + 409 * e + 128);
        px.green = shift_clamp(298 * c - 100 * d - 208 * e + 128);
        px.blue  = shift_clamp(298 * c + 516 * d + 128);
        return px;
    endfunction

    function automatic pixel_pair_t predict_pair(input logic [WORD_W-1:0] w,
                                                 input logic mode);
        pixel_pair_t pp;
        int          d;
        int          e;
        if (mode == MODE_RGB) begin
            pp.first.red    = scale_comp(w, 0);
            pp.first.green  = scale_comp(w, 1);
            pp.first.blue   = scale_comp(w, 2);
            pp.second.red   = scale_comp(w, 3);
            pp.second.green = scale_comp(w, 4);
            pp.second.blue  = scale_comp(w, 5);
        end else begin
            d = int'(scale_comp(w, SLOT_U)) - 128;
            e = int'(scale_comp(w, SLOT_V)) - 128;
            pp.first  = yuv_pixel(scale_comp(w, SLOT_Y0), d, e);
            pp.second = yuv_pixel(scale_comp(w, SLOT_Y1), d, e);
        end
        return pp;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [WORD_W-1:0] pack6(input int f0, input int f1, input int f2,
                                                input int f3, input int f4, input int f5);
        logic [WORD_W-1:0] w;
        w = '0;
        w[0*COMP_W +: COMP_W] = f0[COMP_W-1:0];
        w[1*COMP_W +: COMP_W] = f1[COMP_W-1:0];
        w[2*COMP_W +: COMP_W] = f2[COMP_W-1:0];
        w[3*COMP_W +: COMP_W] = f3[COMP_W-1:0];
        w[4*COMP_W +: COMP_W] = f4[COMP_W-1:0];
        w[5*COMP_W +: COMP_W] = f5[COMP_W-1:0];
        return w;
    endfunction

    function automatic int pick_field();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1023;
            2: return $urandom_range(0, 70);
            3: return $urandom_range(950, 1023);
            4: return $urandom_range(500, 530);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        logic [WORD_W-1:0] w;
        if ($urandom_range(0, 9) < 3) begin
            w = pack6(pick_field(), pick_field(), pick_field(),
                      pick_field(), pick_field(), pick_field());
            w[WORD_W-1:6*COMP_W] = 4'($urandom);
        end else begin
            w = {$urandom, $urandom};
        end
        return w;
    endfunction

    // Called just after the clock rises; returns just after the word is accepted.
    task automatic send_word(input logic [WORD_W-1:0] w, input bit allow_gap);
        int gap;
        if (allow_gap && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left > 0) burst_left--;
        s_valid       <= 1'b1;
        s_packed_word <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_pairs.push_back(predict_pair(w, mode_shadow));
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge aclk);
        repeat (LATENCY + 3) @(posedge aclk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drain();
        cfg_valid                <= 1'b1;
        cfg_rgb_passthrough_mode <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        mode_shadow = mode;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_word(random_word(), 1'b1);
    endtask

    // ---------------- tests ----------------

    // No config write yet: the block must come out of reset in YUV422 mode.
    task automatic test_yuv_directed();
        send_word(pack6(0, 0, 0, 0, 0, 0), 1'b1);
        send_word({WORD_W{1'b1}}, 1'b1);
        send_word(pack6(65, 514, 65, 514, 0, 0), 1'b1);         // black
        send_word(pack6(1023, 514, 1023, 514, 0, 0), 1'b1);     // white
        send_word(pack6(512, 0, 512, 1023, 0, 0), 1'b1);
        send_word(pack6(512, 1023, 512, 0, 0, 0), 1'b1);
        send_word(pack6(0, 514, 1023, 514, 0, 0), 1'b1);
        send_word(pack6(940, 1023, 100, 1023, 0, 0), 1'b1);
        send_word(64'hFFFF_FF00_0000_0000, 1'b1);                // slots 4, 5 and padding only
        wait_drain();
    endtask

    task automatic test_rgb_directed();
        write_mode(MODE_RGB);
        send_word(pack6(0, 0, 0, 0, 0, 0), 1'b1);
        send_word({WORD_W{1'b1}}, 1'b1);
        send_word(64'hF000_0000_0000_0000, 1'b1);                // padding only
        for (int k = 0; k < NUM_COMP; k++)
            send_word(64'(1023) << (k * COMP_W), 1'b1);
        send_word(pack6(1, 2, 3, 4, 5, 1022), 1'b1);
        wait_drain();
    endtask

    task automatic test_random_yuv();
        write_mode(MODE_YUV422);
        send_random(350);
        wait_drain();
    endtask

    task automatic test_random_rgb();
        write_mode(MODE_RGB);
        send_random(300);
        wait_drain();
    endtask

    // Receiver holds off long enough for the pipe to fill and stall s_ready.
    task automatic test_backpressure();
        write_mode(MODE_YUV422);
        hold_left = 300;
        repeat (60) send_word(random_word(), 1'b0);
        wait_drain();
    endtask

    task automatic test_mode_changes();
        logic modes[6];
        modes = '{MODE_RGB, MODE_YUV422, MODE_YUV422, MODE_RGB, MODE_RGB, MODE_YUV422};
        foreach (modes[i]) begin
            write_mode(modes[i]);
            send_random(45);
        end
        wait_drain();
    endtask

    // ---------------- processes ----------------

    initial begin
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_yuv_directed();
        test_rgb_directed();
        test_random_yuv();
        test_backpressure();
        test_random_rgb();
        test_mode_changes();
        wait_drain();

        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver: segments with their own stall rate, plus a long hold on request.
    initial begin
        int seg_left;
        int stall_pct;
        seg_left = 0;
        stall_pct = 0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(5, 60);
                    case ($urandom_range(0, 4))
                        0, 1: stall_pct = 0;
                        2: stall_pct = 20;
                        3: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        pixel_pair_t exp_pair;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $error("result word with no pending expectation");
                error_count++;
            end else begin
                exp_pair = pending_pairs.pop_front();
                if (m_red_first !== exp_pair.first.red) begin
                    $error("red_first expected %0d actual %0d", exp_pair.first.red, m_red_first);
                    error_count++;
                end
                if (m_green_first !== exp_pair.first.green) begin
                    $error("green_first expected %0d actual %0d",
                           exp_pair.first.green, m_green_first);
                    error_count++;
                end
                if (m_blue_first !== exp_pair.first.blue) begin
                    $error("blue_first expected %0d actual %0d",
                           exp_pair.first.blue, m_blue_first);
                    error_count++;
                end
                if (m_red_second !== exp_pair.second.red) begin
                    $error("red_second expected %0d actual %0d",
                           exp_pair.second.red, m_red_second);
                    error_count++;
                end
                if (m_green_second !== exp_pair.second.green) begin
                    $error("green_second expected %0d actual %0d",
                           exp_pair.second.green, m_green_second);
                    error_count++;
                end
                if (m_blue_second !== exp_pair.second.blue) begin
                    $error("blue_second expected %0d actual %0d",
                           exp_pair.second.blue, m_blue_second);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
